// ===== rtl/core/dda_line_rasterizer_top_assert.svh =====
// Assertion macros for the line rasterizer checker.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef DDA_LINE_RASTERIZER_TOP_ASSERT_SVH
`define DDA_LINE_RASTERIZER_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define DLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define DLR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/dlr_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
// No dependencies; every other module of the block imports this package.
`default_nettype none

package dlr_pkg;

    localparam int COORD_FIELD_BITS   = 6;
    localparam int COORD_BITS_DEFAULT = 6;
    localparam int CHAR_BITS          = 8;
    localparam int ADDR_BITS          = 12;
    localparam int ROW_WIDTH_BITS     = 7;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 7'd64;

    typedef logic [COORD_FIELD_BITS-1:0] coord_t;
    typedef logic [CHAR_BITS-1:0]        char_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;
    typedef logic [ROW_WIDTH_BITS-1:0]   row_width_t;

    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        char_t  fill_char;
    } line_in_t;

    typedef struct packed {
        coord_t x_pos;
        coord_t y_pos;
        addr_t  buffer_address;
        char_t  char_out;
        logic   last_point;
    } point_out_t;

    // A classified line as it waits between the front and the back end.
    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t dx_mag;
        coord_t dy_mag;
        logic   dx_neg;
        logic   dy_neg;
        coord_t steps;
        char_t  fill_char;
    } line_cmd_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dlr_queue.sv =====
// Small register queue of classified lines between front and back end.
// Depends on dlr_pkg for the line command type.
`default_nettype none

module dlr_queue #(
    parameter int DEPTH = dlr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire dlr_pkg::line_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output dlr_pkg::line_cmd_t     pop_data,
    output logic                   empty
);
    import dlr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    line_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dlr_front.sv =====
// Front end: accepts line transactions, works out direction, magnitudes and
// step count, drops zero-length lines and queues the rest. Uses dlr_pkg.
`default_nettype none

module dlr_front #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dlr_pkg::line_in_t  s_data,
    output logic                    push,
    output dlr_pkg::line_cmd_t      push_data,
    input  wire logic               full
);
    import dlr_pkg::*;

    localparam int W = COORD_BITS;

    logic [W-1:0] xs, ys, xe, ye;
    logic [W:0]   dx, dy;
    logic [W-1:0] ax, ay, steps;

    always_comb begin
        xs = s_data.x_start[W-1:0];
        ys = s_data.y_start[W-1:0];
        xe = s_data.x_end[W-1:0];
        ye = s_data.y_end[W-1:0];
        dx = {1'b0, xe} - {1'b0, xs};
        dy = {1'b0, ye} - {1'b0, ys};
        ax = dx[W] ? W'(-dx) : dx[W-1:0];
        ay = dy[W] ? W'(-dy) : dy[W-1:0];
        steps = (ax > ay) ? ax : ay;

        push_data.x_start   = COORD_FIELD_BITS'(xs);
        push_data.y_start   = COORD_FIELD_BITS'(ys);
        push_data.dx_mag    = COORD_FIELD_BITS'(ax);
        push_data.dy_mag    = COORD_FIELD_BITS'(ay);
        push_data.dx_neg    = dx[W];
        push_data.dy_neg    = dy[W];
        push_data.steps     = COORD_FIELD_BITS'(steps);
        push_data.fill_char = s_data.fill_char;
    end

    // A line whose endpoints coincide is taken and produces no points.
    assign s_ready = !full;
    assign push    = s_valid && !full && (steps != '0);

endmodule

`default_nettype wire

// ===== rtl/core/dlr_back.sv =====
// Back end: steps a queued line a point per cycle unless stalled, with exact
// remainder accumulation, holding each point in an output register. Uses dlr_pkg.
`default_nettype none

module dlr_back #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dlr_pkg::line_cmd_t    cmd,
    input  wire logic                  empty,
    output logic                       pop,
    input  wire dlr_pkg::row_width_t   row_width,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dlr_pkg::point_out_t        m_data
);
    import dlr_pkg::*;

    localparam int W = COORD_BITS;

    back_state_t  state_reg, state_next;
    logic [W-1:0] xs_reg, ys_reg, ax_reg, ay_reg, steps_reg;
    logic         xneg_reg, yneg_reg;
    char_t        char_reg;
    logic [W-1:0] i_reg, i_next;
    logic [W-1:0] qx_reg, qx_next, rx_reg, rx_next;
    logic [W-1:0] qy_reg, qy_next, ry_reg, ry_next;
    logic         m_valid_reg, m_valid_next;
    point_out_t   m_data_reg, m_data_next;

    logic         slot_free, emit, last, load;
    logic [W-1:0] cmd_ax, cmd_ay, cmd_steps;
    logic [W-1:0] x_cur, y_cur;

    // Remainder step: q and r keep i*a = q*steps + r with r below steps.
    function automatic logic [2*W-1:0] axis_advance(
        input logic [W-1:0] q, input logic [W-1:0] r,
        input logic [W-1:0] a, input logic [W-1:0] steps);
        logic [W:0] sum;
        logic [W:0] red;
        sum = {1'b0, r} + {1'b0, a};
        red = sum - {1'b0, steps};
        if (sum >= {1'b0, steps}) begin
            return {q + 1'b1, red[W-1:0]};
        end
        return {q, sum[W-1:0]};
    endfunction

    // Floor of a negative quotient rounds the magnitude up.
    function automatic logic [W-1:0] axis_point(
        input logic [W-1:0] start, input logic neg,
        input logic [W-1:0] q, input logic [W-1:0] r);
        logic [W-1:0] q_up;
        logic [W-1:0] off;
        q_up = q + W'(r != '0);
        off  = neg ? (~q_up + 1'b1) : q;
        return start + off;
    endfunction

    assign cmd_ax    = cmd.dx_mag[W-1:0];
    assign cmd_ay    = cmd.dy_mag[W-1:0];
    assign cmd_steps = cmd.steps[W-1:0];

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        {qx_next, rx_next} = {qx_reg, rx_reg};
        {qy_next, ry_next} = {qy_reg, ry_reg};
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        slot_free = !m_valid_reg || m_ready;
        emit      = (state_reg == BACK_RUN) && slot_free;
        last      = (i_reg == steps_reg);
        load      = !empty && ((state_reg == BACK_IDLE) || (emit && last));
        pop       = load;

        x_cur = axis_point(xs_reg, xneg_reg, qx_reg, rx_reg);
        y_cur = axis_point(ys_reg, yneg_reg, qy_reg, ry_reg);

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next              = 1'b1;
            m_data_next.x_pos         = COORD_FIELD_BITS'(x_cur);
            m_data_next.y_pos         = COORD_FIELD_BITS'(y_cur);
            m_data_next.buffer_address = ADDR_BITS'(ADDR_BITS'(x_cur)
                + ADDR_BITS'(y_cur) * ADDR_BITS'(row_width));
            m_data_next.char_out      = char_reg;
            m_data_next.last_point    = last;
            i_next = i_reg + 1'b1;
            {qx_next, rx_next} = axis_advance(qx_reg, rx_reg, ax_reg, steps_reg);
            {qy_next, ry_next} = axis_advance(qy_reg, ry_reg, ay_reg, steps_reg);
        end

        // First point of a new line: i = 1, so r = a unless a equals steps.
        if (load) begin
            i_next  = W'(1);
            qx_next = W'(cmd_ax == cmd_steps);
            rx_next = (cmd_ax == cmd_steps) ? '0 : cmd_ax;
            qy_next = W'(cmd_ay == cmd_steps);
            ry_next = (cmd_ay == cmd_steps) ? '0 : cmd_ay;
        end

        unique case (state_reg)
            BACK_IDLE: begin
                if (load) begin
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN: begin
                if (emit && last && !load) begin
                    state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        qx_reg     <= qx_next;
        rx_reg     <= rx_next;
        qy_reg     <= qy_next;
        ry_reg     <= ry_next;
        m_data_reg <= m_data_next;
        if (load) begin
            xs_reg    <= cmd.x_start[W-1:0];
            ys_reg    <= cmd.y_start[W-1:0];
            ax_reg    <= cmd_ax;
            ay_reg    <= cmd_ay;
            xneg_reg  <= cmd.dx_neg;
            yneg_reg  <= cmd.dy_neg;
            steps_reg <= cmd_steps;
            char_reg  <= cmd.fill_char;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dda_line_rasterizer_top.sv =====
// DDA line rasterizer, top level: row width register, front end, line queue
// and back end. Depends on dlr_pkg, dlr_front, dlr_queue and dlr_back.
//
// Each accepted line produces max(|dx|, |dy|) frame-buffer writes, one per
// cycle while m_ready is high, starting with the point after the start point
// and ending with the end point, which carries last_point. The back-end
// stepper emits one point a cycle while the output is not stalled; a line
// has up to 63 steps on a 64-wide grid, and queued lines follow without a gap.
// A line with coinciding endpoints is accepted and produces nothing. The
// front end takes new lines until QUEUE_DEPTH lines wait behind the
// one being drawn. The row width is written through the cfg channel, which is
// always ready, and is meant to change only while no line is in flight.
`default_nettype none

module dda_line_rasterizer_top #(
    parameter int COORD_BITS  = dlr_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = dlr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire dlr_pkg::row_width_t  cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire dlr_pkg::line_in_t    s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dlr_pkg::point_out_t       m_data
);
    import dlr_pkg::*;

    row_width_t row_width_reg, row_width_next;
    logic       push, full, pop, empty;
    line_cmd_t  push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        row_width_next = row_width_reg;
        if (cfg_valid) begin
            row_width_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else begin
            row_width_reg <= row_width_next;
        end
    end

    dlr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    dlr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    dlr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (pop_data),
        .empty     (empty),
        .pop       (pop),
        .row_width (row_width_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dlr_checker.sv =====
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on dlr_pkg and the assertion macros header.
`default_nettype none

`include "dda_line_rasterizer_top_assert.svh"

module dlr_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire dlr_pkg::row_width_t  cfg_data,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire dlr_pkg::point_out_t  m_data
);
    import dlr_pkg::*;

    row_width_t rw_reg;
    logic       prev_valid_reg;
    logic       prev_last_reg;
    coord_t     prev_x_reg, prev_y_reg;
    char_t      prev_char_reg;
    logic       out_accept, out_stall, mid_line;
    coord_t     dx_step, dy_step;
    logic       x_adj, y_adj;
    addr_t      exp_addr;

    assign out_accept = m_valid && m_ready;
    assign out_stall  = m_valid && !m_ready;
    assign mid_line   = out_accept && prev_valid_reg && !prev_last_reg;
    assign dx_step    = m_data.x_pos - prev_x_reg;
    assign dy_step    = m_data.y_pos - prev_y_reg;
    assign x_adj      = (dx_step == '0) || (dx_step == 6'd1) || (dx_step == 6'h3F);
    assign y_adj      = (dy_step == '0) || (dy_step == 6'd1) || (dy_step == 6'h3F);
    assign exp_addr   = ADDR_BITS'(ADDR_BITS'(m_data.x_pos)
        + ADDR_BITS'(m_data.y_pos) * ADDR_BITS'(rw_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rw_reg         <= ROW_WIDTH_RESET;
            prev_valid_reg <= 1'b0;
            prev_last_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                rw_reg <= cfg_data;
            end
            if (out_accept) begin
                prev_valid_reg <= 1'b1;
                prev_last_reg  <= m_data.last_point;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_accept) begin
            prev_x_reg    <= m_data.x_pos;
            prev_y_reg    <= m_data.y_pos;
            prev_char_reg <= m_data.char_out;
        end
    end

    `DLR_ASSERT(a_out_hold, out_stall |=> m_valid && $stable(m_data), "result changed")
    `DLR_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid right after reset")
    `DLR_ASSERT(a_address, m_valid |-> m_data.buffer_address == exp_addr, "bad address")
    `DLR_ASSERT(a_unit_step, mid_line |-> x_adj && y_adj, "points of a line are not adjacent")
    `DLR_ASSERT(a_same_char, mid_line |-> m_data.char_out == prev_char_reg, "character changed")

endmodule

bind dda_line_rasterizer_top dlr_checker u_dlr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

`default_nettype wire
